// ===== rtl/core/tbc_pkg.sv =====
`default_nettype none

package tbc_pkg;

    // Coordinate format: signed Q(CW-FW).FW
    localparam int CW = 32;
    localparam int FW = 16;
    localparam int NV = 3;
    localparam int MAX_VERTS = 9;
    localparam int PLANES = 6;

    // Plane distance, divisor and divider remainder widths
    localparam int DW = CW + 1;
    localparam int SW = CW + 2;
    localparam int RW = CW + 3;
    localparam int CNT_W = $clog2(MAX_VERTS + 1);
    localparam int K_W = $clog2(FW + 1);

    // Configuration register indexes
    localparam int CFG_IW = 3;
    localparam logic [CFG_IW-1:0] REG_MIN_X = 3'd0;
    localparam logic [CFG_IW-1:0] REG_MIN_Y = 3'd1;
    localparam logic [CFG_IW-1:0] REG_MIN_Z = 3'd2;
    localparam logic [CFG_IW-1:0] REG_MAX_X = 3'd3;
    localparam logic [CFG_IW-1:0] REG_MAX_Y = 3'd4;
    localparam logic [CFG_IW-1:0] REG_MAX_Z = 3'd5;

    typedef logic signed [CW-1:0] coord_t;
    typedef logic [NV-1:0][CW-1:0] vtx_t;

    // One vertex item between cells; none marks an empty polygon.
    typedef struct packed {
        logic none;
        logic last;
        vtx_t v;
    } tok_t;

endpackage

`default_nettype wire

// ===== rtl/core/tbc_cell.sv =====
`default_nettype none

module tbc_cell
    import tbc_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire coord_t      plane,
    input  wire logic [1:0]  axis,
    input  wire logic        flip,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire tok_t        in_tok,
    output logic             out_valid,
    input  wire logic        out_ready,
    output tok_t             out_tok
);

    localparam logic [2:0] S_IN    = 3'd0;
    localparam logic [2:0] S_EDGE  = 3'd1;
    localparam logic [2:0] S_DIV   = 3'd2;
    localparam logic [2:0] S_MUL   = 3'd3;
    localparam logic [2:0] S_PUSH  = 3'd4;
    localparam logic [2:0] S_NEXT  = 3'd5;
    localparam logic [2:0] S_FLUSH = 3'd6;

    localparam int PW = DW + FW + 2;

    // Control state
    logic [2:0]       state_reg, state_next;
    logic             have_first_reg, have_first_next;
    logic             close_pend_reg, close_pend_next;
    logic             close_edge_reg, close_edge_next;
    logic             hold_valid_reg, hold_valid_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             push_t_reg, push_t_next;
    logic [K_W-1:0]   k_reg, k_next;
    logic [1:0]       j_reg, j_next;
    logic             ph_reg, ph_next;

    // Payload
    vtx_t                 first_reg, prev_reg, f_reg, t_reg, pv_reg, hold_reg;
    logic signed [DW-1:0] dfirst_reg, dprev_reg, df_reg, dt_reg;
    logic [RW-1:0]        r_reg;
    logic [SW-1:0]        den_reg;
    logic [FW:0]          q_reg;
    logic signed [PW-1:0] prod_reg;

    logic                 in_fire, out_fire;
    logic signed [DW-1:0] d_in;
    logic                 fin, tin;
    logic [DW-1:0]        abs_dt, abs_df;
    logic [RW-1:0]        rr;
    logic                 ge;
    logic signed [DW-1:0] diff;
    logic signed [PW-1:0] prod;
    logic signed [PW-1:0] scaled;
    logic [CW-1:0]        sum;

    // Signed distance of a vertex to this cell's plane; max planes are flipped.
    function automatic logic signed [DW-1:0] dist_f(input vtx_t v, input logic [1:0] ax,
                                                    input coord_t pl, input logic fl);
        logic [CW-1:0]        c;
        logic signed [DW-1:0] ce, pe;
        begin
            case (ax)
                2'd0:    c = v[0];
                2'd1:    c = v[1];
                2'd2:    c = v[2];
                default: c = '0;
            endcase
            ce = $signed({c[CW-1], c});
            pe = $signed({pl[CW-1], pl});
            dist_f = fl ? (pe - ce) : (ce - pe);
        end
    endfunction

    // Handshakes
    assign in_ready  = (state_reg == S_IN);
    assign in_fire   = in_valid && in_ready;
    assign out_valid = (state_reg == S_FLUSH) ||
                       (state_reg == S_PUSH && hold_valid_reg &&
                        cnt_reg != CNT_W'(MAX_VERTS));
    assign out_fire  = out_valid && out_ready;

    // The held vertex goes out flagged last only when the polygon closes.
    always_comb
    begin
        out_tok.none = (state_reg == S_FLUSH) && !hold_valid_reg;
        out_tok.last = (state_reg == S_FLUSH);
        out_tok.v    = out_tok.none ? '0 : hold_reg;
    end

    // Edge classification and crossing arithmetic
    assign d_in   = dist_f(in_tok.v, axis, plane, flip);
    assign fin    = !df_reg[DW-1];
    assign tin    = !dt_reg[DW-1];
    assign abs_dt = dt_reg[DW-1] ? DW'(-dt_reg) : DW'(dt_reg);
    assign abs_df = df_reg[DW-1] ? DW'(-df_reg) : DW'(df_reg);
    assign rr     = (k_reg == '0) ? r_reg : {r_reg[RW-2:0], 1'b0};
    assign ge     = rr >= RW'(den_reg);
    assign diff   = $signed({f_reg[j_reg][CW-1], f_reg[j_reg]}) -
                    $signed({t_reg[j_reg][CW-1], t_reg[j_reg]});
    assign prod   = PW'(diff * $signed({1'b0, q_reg}));
    assign scaled = prod_reg >>> FW;
    assign sum    = t_reg[j_reg] + scaled[CW-1:0];

    // Next control state
    always_comb
    begin
        state_next      = state_reg;
        have_first_next = have_first_reg;
        close_pend_next = close_pend_reg;
        close_edge_next = close_edge_reg;
        hold_valid_next = hold_valid_reg;
        cnt_next        = cnt_reg;
        push_t_next     = push_t_reg;
        k_next          = k_reg;
        j_next          = j_reg;
        ph_next         = ph_reg;
        unique case (state_reg)
            S_IN:
            begin
                if (in_fire)
                begin
                    if (in_tok.none)
                    begin
                        state_next = S_FLUSH;
                    end
                    else if (have_first_reg)
                    begin
                        state_next      = S_EDGE;
                        close_pend_next = in_tok.last;
                        close_edge_next = 1'b0;
                    end
                    else
                    begin
                        have_first_next = 1'b1;
                        if (in_tok.last)
                        begin
                            state_next      = S_EDGE;
                            close_pend_next = 1'b1;
                            close_edge_next = 1'b1;
                        end
                    end
                end
            end
            S_EDGE:
            begin
                if (fin && tin)
                begin
                    state_next  = S_PUSH;
                    push_t_next = 1'b0;
                end
                else if (fin != tin)
                begin
                    state_next  = S_DIV;
                    push_t_next = tin;
                    k_next      = '0;
                end
                else
                begin
                    state_next = S_NEXT;
                end
            end
            S_DIV:
            begin
                k_next = k_reg + 1'b1;
                if (k_reg == K_W'(FW))
                begin
                    state_next = S_MUL;
                    j_next     = '0;
                    ph_next    = 1'b0;
                end
            end
            S_MUL:
            begin
                ph_next = !ph_reg;
                if (ph_reg)
                begin
                    j_next = j_reg + 1'b1;
                    if (j_reg == 2'(NV - 1))
                    begin
                        state_next = S_PUSH;
                    end
                end
            end
            S_PUSH:
            begin
                if (cnt_reg == CNT_W'(MAX_VERTS) || !hold_valid_reg || out_fire)
                begin
                    if (cnt_reg != CNT_W'(MAX_VERTS))
                    begin
                        hold_valid_next = 1'b1;
                        cnt_next        = cnt_reg + 1'b1;
                    end
                    if (push_t_reg)
                    begin
                        push_t_next = 1'b0;
                    end
                    else
                    begin
                        state_next = S_NEXT;
                    end
                end
            end
            S_NEXT:
            begin
                if (close_pend_reg && !close_edge_reg)
                begin
                    state_next      = S_EDGE;
                    close_edge_next = 1'b1;
                end
                else if (close_pend_reg)
                begin
                    state_next = S_FLUSH;
                end
                else
                begin
                    state_next = S_IN;
                end
            end
            S_FLUSH:
            begin
                if (out_fire)
                begin
                    state_next      = S_IN;
                    hold_valid_next = 1'b0;
                    cnt_next        = '0;
                    have_first_next = 1'b0;
                    close_pend_next = 1'b0;
                    close_edge_next = 1'b0;
                end
            end
            default:
            begin
                state_next = S_IN;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IN;
            have_first_reg <= 1'b0;
            close_pend_reg <= 1'b0;
            close_edge_reg <= 1'b0;
            hold_valid_reg <= 1'b0;
            cnt_reg        <= '0;
            push_t_reg     <= 1'b0;
            k_reg          <= '0;
            j_reg          <= '0;
            ph_reg         <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            have_first_reg <= have_first_next;
            close_pend_reg <= close_pend_next;
            close_edge_reg <= close_edge_next;
            hold_valid_reg <= hold_valid_next;
            cnt_reg        <= cnt_next;
            push_t_reg     <= push_t_next;
            k_reg          <= k_next;
            j_reg          <= j_next;
            ph_reg         <= ph_next;
        end
    end

    // Vertex, distance and arithmetic registers
    always_ff @(posedge clk)
    begin
        case (state_reg)
            S_IN:
            begin
                if (in_fire && !in_tok.none)
                begin
                    prev_reg  <= in_tok.v;
                    dprev_reg <= d_in;
                    t_reg     <= in_tok.v;
                    dt_reg    <= d_in;
                    if (have_first_reg)
                    begin
                        f_reg  <= prev_reg;
                        df_reg <= dprev_reg;
                    end
                    else
                    begin
                        first_reg  <= in_tok.v;
                        dfirst_reg <= d_in;
                        f_reg      <= in_tok.v;
                        df_reg     <= d_in;
                    end
                end
            end
            S_EDGE:
            begin
                pv_reg  <= t_reg;
                r_reg   <= RW'(abs_dt);
                den_reg <= SW'(abs_dt) + SW'(abs_df);
                q_reg   <= '0;
            end
            S_DIV:
            begin
                q_reg <= {q_reg[FW-1:0], ge};
                r_reg <= ge ? (rr - RW'(den_reg)) : rr;
            end
            S_MUL:
            begin
                if (!ph_reg)
                begin
                    prod_reg <= prod;
                end
                else
                begin
                    pv_reg[j_reg] <= sum;
                end
            end
            S_PUSH:
            begin
                if (cnt_reg != CNT_W'(MAX_VERTS) && (!hold_valid_reg || out_fire))
                begin
                    hold_reg <= pv_reg;
                end
                if (cnt_reg == CNT_W'(MAX_VERTS) || !hold_valid_reg || out_fire)
                begin
                    pv_reg <= t_reg;
                end
            end
            S_NEXT:
            begin
                if (close_pend_reg && !close_edge_reg)
                begin
                    f_reg  <= prev_reg;
                    df_reg <= dprev_reg;
                    t_reg  <= first_reg;
                    dt_reg <= dfirst_reg;
                end
            end
            default:
            begin
            end
        endcase
    end

    // The output list never grows past its capacity.
    assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CNT_W'(MAX_VERTS))
        else $error("tbc_cell: vertex count overflow");

    // An empty-polygon item only leaves when no vertex was kept.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_tok.none) |-> (cnt_reg == '0))
        else $error("tbc_cell: empty item with kept vertices");

    // A closed polygon clears the cell for the next one.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_fire && state_reg == S_FLUSH) |=> (cnt_reg == '0 && !hold_valid_reg))
        else $error("tbc_cell: state not cleared after polygon");

    // A held vertex always counts toward the list.
    assert property (@(posedge clk) disable iff (!rst_n)
        hold_valid_reg |-> (cnt_reg != '0))
        else $error("tbc_cell: held vertex without count");

endmodule

`default_nettype wire

// ===== rtl/core/triangle_box_clipper_core.sv =====
`default_nettype none

// Clips one triangle against an axis-aligned box (Sutherland-Hodgman, planes x-min, x-max,
// y-min, y-max, z-min, z-max) and streams out the surviving polygon vertices, the last one
// with tlast high, or a single item with tuser high and zero coordinates when nothing is
// left. Six plane cells form a chain; each takes a vertex stream and emits the clipped
// stream to the next cell. A triangle is registered when taken and its three vertices are
// handed to the first cell one at a time, whenever that cell is ready for the next one. A
// cell classifies the edge from the previous to each input vertex after the first; on a
// plane crossing it runs the bit-serial ratio divider and then the cell's multiplier, one
// coordinate at a time. After the last input vertex it closes the polygon with the edge back
// to the first one and emits the last item. A cell takes and emits up to 9 vertices per
// polygon. Triangles overlap in the chain: a new one is taken once the first cell has its
// three vertices. The user must write box registers through the cfg port only while the
// block is idle; the block itself does not enforce this. Indexes above 5 are ignored.
module triangle_box_clipper_core
    import tbc_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    // first_x, first_y, first_z, second_x, second_y, second_z, third_x, third_y, third_z
    input  wire logic [9*CW-1:0]      s_tdata,
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    // out_x, out_y, out_z
    output logic [3*CW-1:0]           m_tdata,
    output logic                      m_tlast,
    // polygon_empty
    output logic                      m_tuser,
    input  wire logic                 cfg_valid,
    output logic                      cfg_ready,
    input  wire logic [CFG_IW-1:0]    cfg_index,
    input  wire logic [CW-1:0]        cfg_data
);

    coord_t            box_reg [PLANES];
    logic [NV-1:0][CW*NV-1:0] tri_reg;
    logic              busy_reg;
    logic [1:0]        feed_reg;

    logic [PLANES:0]   vld;
    logic [PLANES:0]   rdy;
    tok_t              tok [PLANES+1];

    // Box registers
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < PLANES; i++)
            begin
                box_reg[i] <= '0;
            end
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_MIN_X: box_reg[0] <= cfg_data;
                REG_MIN_Y: box_reg[1] <= cfg_data;
                REG_MIN_Z: box_reg[2] <= cfg_data;
                REG_MAX_X: box_reg[3] <= cfg_data;
                REG_MAX_Y: box_reg[4] <= cfg_data;
                REG_MAX_Z: box_reg[5] <= cfg_data;
                default:   ;
            endcase
        end
    end

    // Triangle feeder: hands the three vertices to the first cell in order.
    assign s_tready = !busy_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            feed_reg <= '0;
        end
        else if (s_tvalid && s_tready)
        begin
            busy_reg <= 1'b1;
            feed_reg <= '0;
        end
        else if (vld[0] && rdy[0])
        begin
            if (feed_reg == 2'(NV - 1))
            begin
                busy_reg <= 1'b0;
            end
            feed_reg <= feed_reg + 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            for (int i = 0; i < NV; i++)
            begin
                tri_reg[i] <= s_tdata[i*CW*NV +: CW*NV];
            end
        end
    end

    assign vld[0]       = busy_reg;
    assign tok[0].none  = 1'b0;
    assign tok[0].last  = (feed_reg == 2'(NV - 1));
    assign tok[0].v     = vtx_t'(tri_reg[feed_reg]);

    // Chain of plane cells: min then max plane for each axis.
    for (genvar g = 0; g < PLANES; g++)
    begin : g_cell
        localparam int AX  = g / 2;
        localparam int REG = (g % 2) * 3 + g / 2;

        tbc_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .plane     (box_reg[REG]),
            .axis      (2'(AX)),
            .flip      (1'(g % 2)),
            .in_valid  (vld[g]),
            .in_ready  (rdy[g]),
            .in_tok    (tok[g]),
            .out_valid (vld[g+1]),
            .out_ready (rdy[g+1]),
            .out_tok   (tok[g+1])
        );
    end

    // Result stream
    assign m_tvalid     = vld[PLANES];
    assign rdy[PLANES]  = m_tready;
    assign m_tdata      = tok[PLANES].v;
    assign m_tlast      = tok[PLANES].last;
    assign m_tuser      = tok[PLANES].none;

endmodule

`default_nettype wire

// ===== dv/triangle_box_clipper_core_tb.sv =====
`default_nettype none

module triangle_box_clipper_core_tb;
    import tbc_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int WATCHDOG_LIMIT = 20000;
    localparam int DRAIN_CYCLES = 1500;

    typedef logic signed [63:0] wide_t;

    typedef struct {
        wide_t c[3];
    } point_t;

    typedef struct packed {
        logic [CW-1:0] x;
        logic [CW-1:0] y;
        logic [CW-1:0] z;
        logic          last;
        logic          empty;
    } vertex_out_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic s_tvalid = 1'b0;
    logic s_tready;
    logic [9*CW-1:0] s_tdata = '0;
    logic m_tvalid;
    logic m_tready = 1'b0;
    logic [3*CW-1:0] m_tdata;
    logic m_tlast;
    logic m_tuser;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [CFG_IW-1:0] cfg_index = '0;
    logic [CW-1:0] cfg_data = '0;

    // Box corners as the predictor sees them.
    wide_t box_lo[3];
    wide_t box_hi[3];

    vertex_out_t clipped_q[$];
    int error_count = 0;
    int triangles_sent = 0;
    int vertices_seen = 0;
    int empties_seen = 0;
    int crossings_seen = 0;
    int idle_cycles = 0;
    bit sender_idles = 1'b1;
    bit receiver_idles = 1'b1;

    triangle_box_clipper_core dut (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .m_tlast(m_tlast), .m_tuser(m_tuser),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    always #2 clk = ~clk;

    // floor(num * 2^FW / den) with 0 <= num <= den.
    function automatic wide_t crossing_ratio(wide_t num, wide_t den);
        return (num <<< FW) / den;
    endfunction

    // floor(diff * t / 2^FW); the product fits well within 64 bits.
    function automatic wide_t scaled_step(wide_t diff, wide_t t);
        return (diff * t) >>> FW;
    endfunction

    function automatic wide_t plane_distance(point_t p, int axis, bit flip);
        return flip ? box_hi[axis] - p.c[axis] : p.c[axis] - box_lo[axis];
    endfunction

    function automatic point_t edge_crossing(point_t src, point_t dst, wide_t ds, wide_t dd);
        point_t q;
        wide_t a;
        wide_t b;
        wide_t t;
        a = dd < 0 ? -dd : dd;
        b = ds < 0 ? -ds : ds;
        t = crossing_ratio(a, a + b);
        for (int k = 0; k < 3; k++)
            q.c[k] = dst.c[k] + scaled_step(src.c[k] - dst.c[k], t);
        return q;
    endfunction

    // Clips against all six planes and queues the surviving vertices, or one empty item.
    task automatic predict_clip(logic [9*CW-1:0] tri_bits);
        point_t poly[$];
        point_t nxt[$];
        point_t src;
        point_t dst;
        wide_t ds;
        wide_t dd;
        vertex_out_t r;
        poly = {};
        for (int i = 0; i < 3; i++)
        begin
            for (int k = 0; k < 3; k++)
                src.c[k] = wide_t'(signed'(tri_bits[(i*3+k)*CW +: CW]));
            poly.insert(poly.size(), src);
        end
        for (int plane = 0; plane < PLANES; plane++)
        begin
            nxt = {};
            for (int i = 0; i < poly.size(); i++)
            begin
                src = poly[i];
                dst = poly[(i + 1) % poly.size()];
                ds = plane_distance(src, plane / 2, plane[0]);
                dd = plane_distance(dst, plane / 2, plane[0]);
                if ((ds >= 0) != (dd >= 0))
                begin
                    crossings_seen++;
                    if (nxt.size() < MAX_VERTS)
                        nxt.insert(nxt.size(), edge_crossing(src, dst, ds, dd));
                end
                if (dd >= 0 && nxt.size() < MAX_VERTS)
                    nxt.insert(nxt.size(), dst);
            end
            poly = nxt;
        end
        if (poly.size() == 0)
        begin
            r = '{x: '0, y: '0, z: '0, last: 1'b1, empty: 1'b1};
            clipped_q.insert(clipped_q.size(), r);
            empties_seen++;
        end
        for (int i = 0; i < poly.size(); i++)
        begin
            r.x = poly[i].c[0][CW-1:0];
            r.y = poly[i].c[1][CW-1:0];
            r.z = poly[i].c[2][CW-1:0];
            r.last = (i == poly.size() - 1);
            r.empty = 1'b0;
            clipped_q.insert(clipped_q.size(), r);
        end
    endtask

    task automatic report_mismatch(string what);
        error_count++;
        $display("[%0t] mismatch: %s", $realtime, what);
    endtask

    // The sender drops valid for a random burst of cycles.
    task automatic random_gap(bit enable);
        if (enable && $urandom_range(0, 3) == 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(negedge clk);
        end
    endtask

    // Sends one triangle and predicts its vertices at acceptance; valid is left
    // to the next item or to the next idle period.
    task automatic send_triangle(logic [9*CW-1:0] tri_bits);
        random_gap(sender_idles);
        s_tdata <= tri_bits;
        s_tvalid <= 1'b1;
        do @(posedge clk); while (!s_tready);
        predict_clip(tri_bits);
        triangles_sent++;
        @(negedge clk);
    endtask

    task automatic write_box_reg(logic [CFG_IW-1:0] idx, logic [CW-1:0] value);
        cfg_index <= idx;
        cfg_data <= value;
        cfg_valid <= 1'b1;
        do @(posedge clk); while (!cfg_ready);
        if (idx < 3)
            box_lo[idx] = wide_t'(signed'(value));
        else
            box_hi[idx - 3] = wide_t'(signed'(value));
        @(negedge clk);
    endtask

    // Waits for the chain to empty before the box is changed.
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        while (clipped_q.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    task automatic set_box(logic [CW-1:0] lx, logic [CW-1:0] ly, logic [CW-1:0] lz,
                           logic [CW-1:0] hx, logic [CW-1:0] hy, logic [CW-1:0] hz);
        wait_idle();
        write_box_reg(REG_MIN_X, lx);
        write_box_reg(REG_MIN_Y, ly);
        write_box_reg(REG_MIN_Z, lz);
        write_box_reg(REG_MAX_X, hx);
        write_box_reg(REG_MAX_Y, hy);
        write_box_reg(REG_MAX_Z, hz);
        cfg_valid <= 1'b0;
    endtask

    function automatic logic [9*CW-1:0] make_triangle(logic [CW-1:0] v[9]);
        logic [9*CW-1:0] t;
        for (int i = 0; i < 9; i++)
            t[i*CW +: CW] = v[i];
        return t;
    endfunction

    // A coordinate mostly near the box, sometimes anywhere.
    function automatic logic [CW-1:0] near_box(int axis);
        wide_t lo;
        wide_t hi;
        wide_t span;
        wide_t pick;
        lo = box_lo[axis] < box_hi[axis] ? box_lo[axis] : box_hi[axis];
        hi = box_lo[axis] < box_hi[axis] ? box_hi[axis] : box_lo[axis];
        span = hi - lo + 64'd65536;
        pick = lo - span / 2 + wide_t'($urandom) % (2 * span);
        case ($urandom_range(0, 9))
            0: return $urandom;
            1: return box_lo[axis][CW-1:0];
            2: return box_hi[axis][CW-1:0];
            default: return pick[CW-1:0];
        endcase
    endfunction

    task automatic send_random(int count, bit wide_range);
        logic [CW-1:0] v[9];
        for (int n = 0; n < count; n++)
        begin
            for (int i = 0; i < 9; i++)
                v[i] = wide_range ? $urandom : near_box(i % 3);
            send_triangle(make_triangle(v));
        end
    endtask

    // Directed: reset box, vertices on and across planes, field extremes.
    task automatic test_directed();
        logic [CW-1:0] one = 32'h0001_0000;
        logic [CW-1:0] mn = 32'h8000_0000;
        logic [CW-1:0] mx = 32'h7fff_ffff;
        send_triangle('0);
        send_triangle(make_triangle('{one, 0, 0, 0, one, 0, 0, 0, one}));
        set_box(0, 0, 0, 32'h0002_0000, 32'h0002_0000, 32'h0002_0000);
        // Fully inside, touching planes, and one vertex out on each axis.
        send_triangle(make_triangle('{one, one, one, 0, 0, 0, 32'h0002_0000, 32'h0002_0000, 0}));
        send_triangle(make_triangle('{32'hffff_0000, one, one, one, 0, one, one, one, 0}));
        send_triangle(make_triangle('{one, 32'h0003_0000, one, one, one, 0, 0, one, one}));
        send_triangle(make_triangle('{one, one, 32'h0004_8000, 0, one, one, one, 0, one}));
        // Large triangle spanning the whole box: many crossings, long polygon.
        send_triangle(make_triangle('{32'hfffd_0000, 32'h0001_8000, 32'hfffe_0000,
                                      32'h0005_0000, 32'hfffc_0000, 32'h0001_0000,
                                      32'h0001_0000, 32'h0006_0000, 32'h0004_0000}));
        send_triangle(make_triangle('{mn, mn, mn, mx, mx, mx, mn, mx, mn}));
        send_triangle(make_triangle('{mx, mx, mx, mx, mx, mx, mx, mx, mx}));
        send_triangle(make_triangle('{mn, 0, one, mx, one, 0, 0, mn, mx}));
        // Inverted box leaves nothing.
        set_box(32'h0002_0000, 0, 0, 0, 32'h0002_0000, 32'h0002_0000);
        send_triangle(make_triangle('{one, one, one, 0, 0, 0, 32'h0002_0000, one, 0}));
        // Extreme box corners.
        set_box(mn, mn, mn, mx, mx, mx);
        send_triangle(make_triangle('{mn, mn, mn, mx, mx, mx, 0, mx, mn}));
        send_triangle(make_triangle('{32'hdead_beef, 32'h1234_5678, mn, mx, 0, one,
                                      32'hffff_ffff, 32'h0000_0001, 32'h5555_aaaa}));
        set_box(mx, mx, mx, mn, mn, mn);
        send_triangle(make_triangle('{mx, mx, mx, mx, mn, mx, mx, mx, mn}));
    endtask

    // Random triangles under a series of box settings.
    task automatic test_random_boxes();
        set_box(32'hfffe_0000, 32'hffff_0000, 32'hfffd_8000,
                32'h0002_0000, 32'h0001_8000, 32'h0000_4000);
        send_random(80, 1'b0);
        // Hold off until the chain has emptied, then go on.
        s_tvalid <= 1'b0;
        while (clipped_q.size() != 0)
            @(negedge clk);
        send_random(40, 1'b0);
        set_box($urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
        send_random(30, 1'b1);
        set_box(32'hc000_0000, 32'hc000_0000, 32'hc000_0000,
                32'h4000_0000, 32'h4000_0000, 32'h4000_0000);
        send_random(60, 1'b1);
        set_box(32'h0000_0100, 32'hffff_ff00, 0, 32'h0000_0400, 32'h0000_0000, 32'h0000_0010);
        send_random(60, 1'b0);
    endtask

    // Back-to-back items with no idling on either side.
    task automatic test_full_rate();
        sender_idles = 1'b0;
        receiver_idles = 1'b0;
        set_box(32'hffff_0000, 32'hffff_0000, 32'hffff_0000,
                32'h0001_0000, 32'h0001_0000, 32'h0001_0000);
        send_random(70, 1'b0);
    endtask

    // Receiver stalls in random bursts.
    initial
    begin
        forever
        begin
            @(negedge clk);
            if (receiver_idles && $urandom_range(0, 3) == 0)
            begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 8)) @(negedge clk);
            end
            m_tready <= 1'b1;
        end
    end

    // Result checker.
    always @(posedge clk)
    begin
        vertex_out_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            vertices_seen++;
            if (clipped_q.size() == 0)
                report_mismatch("vertex with nothing expected");
            else
            begin
                want = clipped_q.pop_front();
                if (m_tdata[0 +: CW] !== want.x)
                    report_mismatch($sformatf("x %h want %h", m_tdata[0 +: CW], want.x));
                if (m_tdata[CW +: CW] !== want.y)
                    report_mismatch($sformatf("y %h want %h", m_tdata[CW +: CW], want.y));
                if (m_tdata[2*CW +: CW] !== want.z)
                    report_mismatch($sformatf("z %h want %h", m_tdata[2*CW +: CW], want.z));
                if (m_tlast !== want.last)
                    report_mismatch($sformatf("last %b want %b", m_tlast, want.last));
                if (m_tuser !== want.empty)
                    report_mismatch($sformatf("empty %b want %b", m_tuser, want.empty));
            end
        end
    end

    // Watchdog on cycles without any accepted item.
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > WATCHDOG_LIMIT)
        begin
            $display("watchdog expired with %0d vertices pending", clipped_q.size());
            $display("*** FAILED ***");
            $finish;
        end
    end

    initial
    begin
        for (int k = 0; k < 3; k++)
        begin
            box_lo[k] = 0;
            box_hi[k] = 0;
        end
        repeat (9) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);
        test_directed();
        test_random_boxes();
        test_full_rate();
        wait_idle();
        $display("Clipped %0d triangles into %0d vertices (%0d empty, %0d plane crossings),",
                 triangles_sent, vertices_seen, empties_seen, crossings_seen);
        $display("over reset, inverted, extreme and random boxes with %0d mismatches.",
                 error_count);
        if (error_count == 0 && clipped_q.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

`default_nettype wire
